// ===== hw/rtl/hsfr_pkg.sv =====
// shared types, constants and helpers for the header synced frame receiver
`timescale 1ns / 1ps

package hsfr_pkg;

   // frame geometry
   localparam int HEADER_LEN = 4;
   localparam int FRAME_MAX  = 256;

   // derived widths
   localparam int COUNT_W = $clog2(FRAME_MAX + 1);
   localparam int ADDR_W  = $clog2(FRAME_MAX);
   localparam int HIDX_W  = (HEADER_LEN > 1) ? $clog2(HEADER_LEN) : 1;

   // fixed field widths
   localparam int BYTE_W     = 8;
   localparam int FLEN_W     = 9;
   localparam int PATTERN_W  = 32;
   localparam int OP_W       = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int PATTERN_BYTES = PATTERN_W / BYTE_W;

   // operation codes
   localparam logic [OP_W-1:0] OP_RX_BYTE = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR   = 2'd1;
   localparam logic [OP_W-1:0] OP_READ    = 2'd2;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_LENGTH    = 2'd0,
      CSR_HEADER_PATTERN  = 2'd1,
      CSR_TERMINATOR_MODE = 2'd2,
      CSR_END_BYTE        = 2'd3
   } csr_index_type;

   // register reset values
   localparam logic [FLEN_W-1:0] FRAME_LENGTH_RESET = 9'd256;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [BYTE_W-1:0] rx_byte;
      logic              line_error;
      logic [BYTE_W-1:0] read_index;
   } req_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  read_data;
      logic               frame_ready;
      logic [COUNT_W-1:0] byte_count;
   } rsp_item_type;

   typedef struct packed {
      logic [FLEN_W-1:0]    frame_length;
      logic [PATTERN_W-1:0] header_pattern;
      logic                 terminator_mode;
      logic [BYTE_W-1:0]    end_byte;
   } cfg_type;

   // frame store access from the core
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [BYTE_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } store_req_type;

   // per item result from the core, before the result register
   typedef struct packed {
      logic               frame_ready;
      logic [COUNT_W-1:0] byte_count;
      logic [BYTE_W-1:0]  head_data;
      logic               sel_store;
   } core_res_type;

   // expected header byte at a window position, zero past the pattern
   function automatic logic [BYTE_W-1:0] expected_header_byte(
      input logic [PATTERN_W-1:0] pattern,
      input int                   pos
   );
      logic [BYTE_W-1:0] result;
      result = '0;
      if (pos < PATTERN_BYTES) begin
         result = pattern[pos*BYTE_W +: BYTE_W];
      end
      return result;
   endfunction

endpackage

// ===== hw/rtl/hsfr_csr.sv =====
// configuration registers of the frame receiver
`timescale 1ns / 1ps

module hsfr_csr
   import hsfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_LENGTH: begin
               cfg_in.frame_length = csr_wr_data[FLEN_W-1:0];
            end
            CSR_HEADER_PATTERN: begin
               cfg_in.header_pattern = csr_wr_data[PATTERN_W-1:0];
            end
            CSR_TERMINATOR_MODE: begin
               cfg_in.terminator_mode = csr_wr_data[0];
            end
            CSR_END_BYTE: begin
               cfg_in.end_byte = csr_wr_data[BYTE_W-1:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_length    <= FRAME_LENGTH_RESET;
         cfg_ff.header_pattern  <= '0;
         cfg_ff.terminator_mode <= 1'b0;
         cfg_ff.end_byte        <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/hsfr_store.sv =====
// frame store memory with per entry valid bits, registered read
`timescale 1ns / 1ps

module hsfr_store
   import hsfr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  store_req_type     store_req,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0]    mem [FRAME_MAX];
   logic [FRAME_MAX-1:0] valid_ff;
   logic [BYTE_W-1:0]    rd_data_ff;
   logic                 rd_valid_ff;

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         mem[store_req.wr_addr] <= store_req.wr_data;
      end
      if (store_req.rd_en) begin
         rd_data_ff  <= mem[store_req.rd_addr];
         rd_valid_ff <= valid_ff[store_req.rd_addr];
      end
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (store_req.wr_en) begin
         valid_ff[store_req.wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ===== hw/rtl/hsfr_core.sv =====
// framing state: header window, header bytes of the store, fill count, ready flag
`timescale 1ns / 1ps

module hsfr_core
   import hsfr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          enable,
   input  req_item_type  item,
   input  cfg_type       cfg,
   output store_req_type store_req,
   output core_res_type  res
);

   logic [BYTE_W-1:0]  win_ff  [HEADER_LEN];
   logic [BYTE_W-1:0]  win_in  [HEADER_LEN];
   logic [BYTE_W-1:0]  head_ff [HEADER_LEN];
   logic [BYTE_W-1:0]  head_in [HEADER_LEN];
   logic [COUNT_W-1:0] fill_ff;
   logic [COUNT_W-1:0] fill_in;
   logic               ready_ff;
   logic               ready_in;

   logic [COUNT_W-1:0] frame_len;
   logic [HIDX_W-1:0]  fill_idx;
   logic [HIDX_W-1:0]  read_hidx;
   logic               in_header;
   logic               below_len;

   // length clamped to the store size
   always_comb begin
      if (32'(cfg.frame_length) > FRAME_MAX) begin
         frame_len = COUNT_W'(FRAME_MAX);
      end else begin
         frame_len = COUNT_W'(cfg.frame_length);
      end
   end

   assign fill_idx  = fill_ff[HIDX_W-1:0];
   assign read_hidx = item.read_index[HIDX_W-1:0];
   assign in_header = (32'(fill_ff) < HEADER_LEN);
   assign below_len = (fill_ff < frame_len);

   // next state and store access for one item
   always_comb begin
      logic [BYTE_W-1:0] filled [HEADER_LEN];
      logic              match;
      logic              slide;

      win_in    = win_ff;
      head_in   = head_ff;
      fill_in   = fill_ff;
      ready_in  = ready_ff;
      filled    = win_ff;
      match     = 1'b1;
      slide     = 1'b0;
      store_req = '0;
      res       = '0;

      unique case (item.operation)
         OP_RX_BYTE: begin
            if (!item.line_error) begin
               if (cfg.terminator_mode) begin
                  // end byte framing, no header
                  if (below_len) begin
                     if (in_header) begin
                        head_in[fill_idx] = item.rx_byte;
                     end else begin
                        store_req.wr_en   = 1'b1;
                        store_req.wr_addr = fill_ff[ADDR_W-1:0];
                        store_req.wr_data = item.rx_byte;
                     end
                     fill_in = fill_ff + COUNT_W'(1);
                  end
                  if ((fill_in == frame_len) || (item.rx_byte == cfg.end_byte)) begin
                     ready_in = 1'b1;
                  end
               end else begin
                  // header sync framing
                  if (in_header) begin
                     ready_in          = 1'b0;
                     filled[fill_idx]  = item.rx_byte;
                     win_in[fill_idx]  = item.rx_byte;
                     head_in[fill_idx] = item.rx_byte;
                     fill_in           = fill_ff + COUNT_W'(1);
                     if (32'(fill_in) == HEADER_LEN) begin
                        for (int i = 0; i < HEADER_LEN; i++) begin
                           if (filled[i] != expected_header_byte(cfg.header_pattern, i)) begin
                              match = 1'b0;
                           end
                        end
                        // mismatch: slide the window left by one byte
                        if (!match) begin
                           slide = 1'b1;
                           for (int i = 0; i < HEADER_LEN - 1; i++) begin
                              win_in[i]  = filled[i+1];
                              head_in[i] = filled[i+1];
                           end
                           win_in[HEADER_LEN-1] = '0;
                           fill_in = COUNT_W'(HEADER_LEN - 1);
                        end
                     end
                  end else if (below_len) begin
                     store_req.wr_en   = 1'b1;
                     store_req.wr_addr = fill_ff[ADDR_W-1:0];
                     store_req.wr_data = item.rx_byte;
                     fill_in           = fill_ff + COUNT_W'(1);
                  end
                  // frame complete
                  if (!slide && (fill_in == frame_len)) begin
                     ready_in = 1'b1;
                     for (int i = 0; i < HEADER_LEN; i++) begin
                        win_in[i] = '0;
                     end
                  end
               end
            end
         end
         OP_CLEAR: begin
            fill_in  = '0;
            ready_in = 1'b0;
         end
         OP_READ: begin
            if (32'(item.read_index) < FRAME_MAX) begin
               if (32'(item.read_index) < HEADER_LEN) begin
                  res.head_data = head_ff[read_hidx];
               end else begin
                  res.sel_store     = 1'b1;
                  store_req.rd_en   = enable;
                  store_req.rd_addr = ADDR_W'(item.read_index);
               end
            end
         end
         default: begin
         end
      endcase

      store_req.wr_en = store_req.wr_en & enable;
      res.frame_ready = ready_in;
      res.byte_count  = fill_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         ready_ff <= 1'b0;
      end else if (enable) begin
         fill_ff  <= fill_in;
         ready_ff <= ready_in;
      end
   end

   // header window and header bytes of the store
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HEADER_LEN; i++) begin
            win_ff[i]  <= '0;
            head_ff[i] <= '0;
         end
      end else if (enable) begin
         win_ff  <= win_in;
         head_ff <= head_in;
      end
   end

   // count never runs past the store
   assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= FRAME_MAX)
      else $error("fill count beyond frame store");

   // store writes only past the header positions
   assert property (@(posedge clock) disable iff (reset)
      store_req.wr_en |-> (32'(store_req.wr_addr) >= HEADER_LEN))
      else $error("store write inside header area");

   // a header mismatch leaves one byte short of a full window
   assert property (@(posedge clock) disable iff (reset)
      (enable && (item.operation == OP_RX_BYTE) && !item.line_error
       && !cfg.terminator_mode && in_header)
      |=> (32'(fill_ff) <= HEADER_LEN))
      else $error("header phase overran window");

endmodule

// ===== hw/rtl/header_synced_frame_receiver.sv =====
// Header synced frame receiver: an item passes the input register, then the result
// register, to reach rsp. One item is taken every cycle while rsp is not stalled; the
// single pass through the framing logic and the one port frame store set that rate.
// Synchronous active high reset empties both registers, clears count, ready flag,
// header window and every frame store valid bit, and loads the register defaults.
`timescale 1ns / 1ps

module header_synced_frame_receiver
   import hsfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_item_type          req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_item_type          rsp_item,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   cfg_type       cfg;
   store_req_type store_req;
   core_res_type  core_res;
   logic [BYTE_W-1:0] store_rd_data;

   logic         in_valid_ff;
   logic         in_valid_in;
   req_item_type in_item_ff;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   core_res_type rsp_res_ff;
   logic         fire;
   logic         req_take;

   hsfr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   hsfr_core u_core (
      .clock     (clock),
      .reset     (reset),
      .enable    (fire),
      .item      (in_item_ff),
      .cfg       (cfg),
      .store_req (store_req),
      .res       (core_res)
   );

   hsfr_store u_store (
      .clock     (clock),
      .reset     (reset),
      .store_req (store_req),
      .rd_data   (store_rd_data)
   );

   // handshake between input and result registers
   assign fire      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = in_valid_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (fire) begin
         in_valid_in  = 1'b0;
         rsp_valid_in = 1'b1;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input item and result payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
      if (fire) begin
         rsp_res_ff <= core_res;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_item.read_data   = rsp_res_ff.sel_store ? store_rd_data : rsp_res_ff.head_data;
   assign rsp_item.frame_ready = rsp_res_ff.frame_ready;
   assign rsp_item.byte_count  = rsp_res_ff.byte_count;

   // a held item is never dropped
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !fire) |=> in_valid_ff)
      else $error("held item lost");

   // clear gives an empty, not ready result
   assert property (@(posedge clock) disable iff (reset)
      (fire && (in_item_ff.operation == OP_CLEAR))
      |=> (rsp_item.byte_count == '0) && !rsp_item.frame_ready)
      else $error("clear not reflected in result");

   // only read items return data
   assert property (@(posedge clock) disable iff (reset)
      (fire && (in_item_ff.operation != OP_READ)) |=> (rsp_item.read_data == '0))
      else $error("read data on a non read item");

   // a finished result is replaced only once taken
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !fire)
      else $error("result overwritten while stalled");

endmodule

// ===== tb/header_synced_frame_receiver_checker.sv =====
// checker that predicts and compares the frame receiver's status items
`timescale 1ns / 1ps

module header_synced_frame_receiver_checker
   import hsfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_item_type          req_item,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_item_type          rsp_item,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output int                    fail_count,
   output int                    pending_count,
   output int                    checked_count
);

   // predicted framer state and register copy
   cfg_type           regs;
   logic [BYTE_W-1:0] window [HEADER_LEN];
   logic [BYTE_W-1:0] store  [FRAME_MAX];
   int                fill;
   logic              ready;

   // status items still owed by the block, oldest first
   rsp_item_type      frame_status_q [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
      checked_count = 0;
   end

   // header byte wanted at a window position, zero past the pattern
   function automatic logic [BYTE_W-1:0] header_byte_at(int pos);
      logic [BYTE_W-1:0] hb;
      hb = '0;
      if (pos < PATTERN_BYTES) begin
         hb = regs.header_pattern[pos*BYTE_W +: BYTE_W];
      end
      return hb;
   endfunction

   // frame length clipped to the store size
   function automatic int frame_limit();
      return (regs.frame_length > FRAME_MAX) ? FRAME_MAX : int'(regs.frame_length);
   endfunction

   // header search, then payload up to the frame length
   function automatic void take_synced(logic [BYTE_W-1:0] b);
      int len;
      int i;
      bit match;
      len = frame_limit();
      if (fill < HEADER_LEN) begin
         ready        = 1'b0;
         window[fill] = b;
         store[fill]  = b;
         fill++;
         if (fill == HEADER_LEN) begin
            match = 1'b1;
            for (i = 0; i < HEADER_LEN; i++) begin
               if (window[i] != header_byte_at(i)) match = 1'b0;
            end
            // no match: slide the window left and give back one byte
            if (!match) begin
               for (i = 0; i < HEADER_LEN - 1; i++) begin
                  window[i] = window[i+1];
                  store[i]  = window[i];
               end
               window[HEADER_LEN-1] = '0;
               fill--;
               return;
            end
         end
      end else if (fill < len) begin
         store[fill] = b;
         fill++;
      end
      if (fill == len) begin
         ready = 1'b1;
         for (i = 0; i < HEADER_LEN; i++) window[i] = '0;
      end
   endfunction

   // no header: store up to the length, end byte also completes
   function automatic void take_terminated(logic [BYTE_W-1:0] b);
      int len;
      len = frame_limit();
      if (fill < len) begin
         store[fill] = b;
         fill++;
      end
      if (fill == len) ready = 1'b1;
      if (b == regs.end_byte) ready = 1'b1;
   endfunction

   // apply one item and form the status item it gives
   function automatic rsp_item_type advance_framer(req_item_type it);
      rsp_item_type r;
      r = '0;
      case (it.operation)
         OP_RX_BYTE: begin
            if (!it.line_error) begin
               if (regs.terminator_mode) take_terminated(it.rx_byte);
               else take_synced(it.rx_byte);
            end
         end
         OP_CLEAR: begin
            fill  = 0;
            ready = 1'b0;
         end
         OP_READ: begin
            if (it.read_index < FRAME_MAX) r.read_data = store[it.read_index];
         end
         default: ;
      endcase
      r.frame_ready = ready;
      r.byte_count  = COUNT_W'(fill);
      return r;
   endfunction

   function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t ns: %s mismatch, expected %h, got %h", $time, field, want, got);
      end
   endfunction

   // watch both channels and the register port
   always @(posedge clock) begin : watch
      rsp_item_type want;
      int i;
      if (reset) begin
         regs = '0;
         regs.frame_length = FRAME_LENGTH_RESET;
         for (i = 0; i < HEADER_LEN; i++) window[i] = '0;
         for (i = 0; i < FRAME_MAX; i++) store[i] = '0;
         fill  = 0;
         ready = 1'b0;
         frame_status_q.delete();
      end else begin
         // results first, so an item taken at this edge is not matched early
         if (rsp_valid && !rsp_stall) begin
            if (frame_status_q.size() == 0) begin
               fail_count++;
               $display("%0t ns: unexpected status item, expected none, got %h",
                        $time, rsp_item);
            end else begin
               want = frame_status_q.pop_front();
               checked_count++;
               check_field("read_data", 16'(want.read_data), 16'(rsp_item.read_data));
               check_field("frame_ready", 16'(want.frame_ready), 16'(rsp_item.frame_ready));
               check_field("byte_count", 16'(want.byte_count), 16'(rsp_item.byte_count));
            end
         end
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_FRAME_LENGTH:    regs.frame_length    = csr_wr_data[FLEN_W-1:0];
               CSR_HEADER_PATTERN:  regs.header_pattern  = csr_wr_data[PATTERN_W-1:0];
               CSR_TERMINATOR_MODE: regs.terminator_mode = csr_wr_data[0];
               CSR_END_BYTE:        regs.end_byte        = csr_wr_data[BYTE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) frame_status_q.push_back(advance_framer(req_item));
      end
      pending_count <= frame_status_q.size();
   end

endmodule

// ===== tb/header_synced_frame_receiver_tb.sv =====
// testbench top: stimulus, output stalls, watchdog and verdict for the frame receiver
`timescale 1ns / 1ps

module header_synced_frame_receiver_tb;
   import hsfr_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int HOLD_AT        = 60;
   localparam int HOLD_CYCLES    = 200;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 4;
   localparam int REQ_W          = $bits(req_item_type);

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_item_type          req_item    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_item_type          rsp_item;
   logic                  csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   int fail_count;
   int pending_count;
   int checked_count;

   // settings last written, used to shape frames
   logic [FLEN_W-1:0]    cur_len     = FRAME_LENGTH_RESET;
   logic [PATTERN_W-1:0] cur_pattern = '0;
   logic                 cur_term    = 1'b0;
   logic [BYTE_W-1:0]    cur_end     = '0;

   // one junk byte ahead of a matching header, then payload and an extra byte
   logic [BYTE_W-1:0] synced_seq [8] = '{8'h55, 8'hD4, 8'hC3, 8'hB2,
                                         8'hA1, 8'hFF, 8'h00, 8'h77};

   bit req_idle_en = 1'b1;
   bit rsp_idle_en = 1'b1;
   bit hold_done   = 1'b0;
   int hold_left   = 0;
   int burst_left  = 0;
   int idle_cycles = 0;
   int offered     = 0;

   header_synced_frame_receiver dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   header_synced_frame_receiver_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_item      (req_item),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_item      (rsp_item),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   always #4 clock = ~clock;

   // output stalls: one long hold-off and random bursts
   always @(negedge clock) begin
      if (!hold_done && offered >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (burst_left > 0) begin
         burst_left--;
         rsp_stall <= 1'b1;
      end else if (rsp_idle_en && $urandom_range(0, 4) == 0) begin
         burst_left = $urandom_range(0, 9);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watchdog on cycles with no item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("header_synced_frame_receiver verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic req_item_type make_item(logic [OP_W-1:0] op, logic [BYTE_W-1:0] b,
                                              logic err, logic [BYTE_W-1:0] idx);
      req_item_type it;
      it.operation  = op;
      it.rx_byte    = b;
      it.line_error = err;
      it.read_index = idx;
      return it;
   endfunction

   // present one item from a falling edge and hold it until taken
   task automatic offer_item(req_item_type it);
      if (req_idle_en && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (req_stall);
      offered++;
      @(negedge clock);
   endtask

   // stop sending and let every owed status item come back
   task automatic wait_results();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // write all four registers while the block is idle
   task automatic set_config(logic [FLEN_W-1:0] len, logic [PATTERN_W-1:0] pattern,
                             logic term, logic [BYTE_W-1:0] endb);
      wait_results();
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_FRAME_LENGTH;
      csr_wr_data <= CSR_DATA_W'(len);
      @(negedge clock);
      csr_index   <= CSR_HEADER_PATTERN;
      csr_wr_data <= pattern;
      @(negedge clock);
      csr_index   <= CSR_TERMINATOR_MODE;
      csr_wr_data <= CSR_DATA_W'(term);
      @(negedge clock);
      csr_index   <= CSR_END_BYTE;
      csr_wr_data <= CSR_DATA_W'(endb);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      cur_len     = len;
      cur_pattern = pattern;
      cur_term    = term;
      cur_end     = endb;
   endtask

   // one well-formed frame with some noise, then reads and usually a clear
   task automatic send_frame();
      int eff;
      int n;
      int i;
      logic [BYTE_W-1:0] b;
      eff = (cur_len > FRAME_MAX) ? FRAME_MAX : int'(cur_len);
      // leading junk for the header search to slide past
      repeat ($urandom_range(0, 2))
         offer_item(make_item(OP_RX_BYTE, BYTE_W'($urandom), 1'b0, BYTE_W'($urandom)));
      if (!cur_term) begin
         for (i = 0; i < HEADER_LEN; i++) begin
            if ($urandom_range(0, 9) == 0)
               offer_item(make_item(OP_RX_BYTE, BYTE_W'($urandom), 1'b1, BYTE_W'($urandom)));
            offer_item(make_item(OP_RX_BYTE,
                                 (i < PATTERN_BYTES) ? cur_pattern[i*BYTE_W +: BYTE_W] : '0,
                                 1'b0, BYTE_W'($urandom)));
         end
         n = (eff > HEADER_LEN) ? eff - HEADER_LEN : 0;
      end else begin
         n = (eff < 24) ? eff : 24;
      end
      // payload, running a little past the length
      n += $urandom_range(0, 2);
      for (i = 0; i < n; i++) begin
         b = (cur_term && $urandom_range(0, 7) == 0) ? cur_end : BYTE_W'($urandom);
         offer_item(make_item(OP_RX_BYTE, b, $urandom_range(0, 15) == 0, BYTE_W'($urandom)));
      end
      repeat ($urandom_range(1, 3))
         offer_item(make_item(OP_READ, BYTE_W'($urandom), 1'($urandom_range(0, 1)),
                              $urandom_range(0, 1) ? BYTE_W'($urandom_range(0, 15))
                                                   : BYTE_W'($urandom)));
      if ($urandom_range(0, 4) != 0)
         offer_item(make_item(OP_CLEAR, BYTE_W'($urandom), 1'($urandom_range(0, 1)),
                              BYTE_W'($urandom)));
   endtask

   // mostly frames, the rest raw random items of any operation
   task automatic run_phase(int quota);
      int target;
      logic [REQ_W-1:0] raw;
      target = offered + quota;
      while (offered < target) begin
         if ($urandom_range(0, 9) < 7) begin
            send_frame();
         end else begin
            raw = REQ_W'($urandom);
            offer_item(raw);
         end
      end
   endtask

   initial begin : stimulus
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // default settings: a read of an untouched store, unused op, dropped byte
      offer_item(make_item(OP_READ, 8'h00, 1'b0, 8'hFF));
      offer_item(make_item(OP_UNUSED, 8'hFF, 1'b1, 8'h00));
      offer_item(make_item(OP_RX_BYTE, 8'hFF, 1'b1, 8'hFF));

      // header sync with one junk byte slid out, frame complete, extra byte ignored
      set_config(9'd6, 32'hA1B2C3D4, 1'b0, 8'h7E);
      foreach (synced_seq[i]) offer_item(make_item(OP_RX_BYTE, synced_seq[i], 1'b0, 8'h00));
      offer_item(make_item(OP_READ, 8'h00, 1'b0, 8'h00));
      offer_item(make_item(OP_READ, 8'h00, 1'b0, 8'h05));
      offer_item(make_item(OP_READ, 8'h00, 1'b0, 8'd200));
      offer_item(make_item(OP_CLEAR, 8'h00, 1'b0, 8'h00));

      // frame length shorter than the header: ready rises then drops
      set_config(9'd2, 32'h0, 1'b0, 8'h7E);
      offer_item(make_item(OP_RX_BYTE, 8'h01, 1'b0, 8'h00));
      offer_item(make_item(OP_RX_BYTE, 8'h02, 1'b0, 8'h00));
      offer_item(make_item(OP_RX_BYTE, 8'h03, 1'b0, 8'h00));

      // end-byte mode entered mid-frame, then zero frame length
      set_config(9'd0, 32'h0, 1'b1, 8'hFF);
      offer_item(make_item(OP_RX_BYTE, 8'h10, 1'b0, 8'h00));
      offer_item(make_item(OP_RX_BYTE, 8'hFF, 1'b0, 8'h00));
      offer_item(make_item(OP_CLEAR, 8'h00, 1'b0, 8'h00));
      offer_item(make_item(OP_RX_BYTE, 8'h20, 1'b0, 8'h00));

      // random phases over a spread of settings
      set_config(9'd8, $urandom, 1'b0, BYTE_W'($urandom));
      run_phase(50);
      set_config(9'd1, 32'hFFFF_FFFF, 1'b0, 8'h00);
      run_phase(30);
      set_config(9'd0, $urandom, 1'b1, BYTE_W'($urandom));
      run_phase(30);
      set_config(9'd300, 32'h0, 1'b0, BYTE_W'($urandom));
      run_phase(250);
      set_config(9'($urandom_range(5, 20)), $urandom, 1'b1, 8'h00);
      run_phase(50);
      set_config(9'd511, $urandom, 1'b1, 8'hFF);
      run_phase(40);

      // closing stretch with no idling on either side
      set_config(9'($urandom_range(3, 12)), $urandom, 1'b0, BYTE_W'($urandom));
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      run_phase(60);

      wait_results();
      $display("covered %0d items: directed corners, header-sync and end-byte framing,",
               offered);
      $display("%0d status items compared, including a long output hold-off", checked_count);
      if (fail_count == 0) begin
         $display("header_synced_frame_receiver verification clean");
      end else begin
         $display("header_synced_frame_receiver verification failed");
      end
      $finish;
   end

endmodule
